// ===== src/pll_pkg.sv =====
// package for the positional line list
// holds command and status codes, controller states and the cell control bundle
// no dependencies
`default_nettype none

package pll_pkg;

  // field widths fixed by the interface
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned PORT_H_W = 32;
  localparam int unsigned STAT_W   = 2;

  // operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_MOVE    = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_BAD_LINE = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_LOOK,
    S_DONE
  } state_t;

  // per-operation control broadcast to every cell
  typedef struct packed {
    logic en;         // apply the update this cycle
    logic load_en;    // one cell loads a new handle
    logic src_moved;  // load value is the moved line, not the input handle
    logic shift_en;   // a range of cells takes a neighbor's value
    logic from_left;  // 1: take lower neighbor, 0: take upper neighbor
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== src/positional_line_list.sv =====
// top level of the positional line list: controller, cell chain and read port
// uses pll_pkg, pll_cell and pll_read
//
//  channel | direction | ports                                        | handshake
//  in      | input     | in_cmd in_position in_dest_position          | in_valid / in_stall
//          |           | in_line_handle                               |
//  out     | output    | out_status out_line_count                    | out_valid / out_stall
//          |           | out_line_at_position                         |
//
// from acceptance to a valid result an item passes through FETCH, which reads the
// moved line through the shared read port, EXEC, in which the whole chain shifts
// and loads at once, and LOOK, which reads the line now at position n; in DONE the
// result stands in the output registers. the next item is accepted only once the
// result is taken, so a new item never enters while one is in flight.
// reset clears the line count and the controller; cells need no clearing since
// only positions below the count are read. out_stall holds the result registers.
`default_nettype none

module positional_line_list
  import pll_pkg::*;
#(
  parameter int unsigned MAX_LINES    = 64,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [CMD_W-1:0]            in_cmd,
  input  wire logic [POS_W-1:0]            in_position,
  input  wire logic [POS_W-1:0]            in_dest_position,
  input  wire logic [PORT_H_W-1:0]         in_line_handle,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [STAT_W-1:0]                out_status,
  output logic [$clog2(MAX_LINES+1)-1:0]   out_line_count,
  output logic [PORT_H_W-1:0]              out_line_at_position
);

  localparam int unsigned IDX_W = $clog2(MAX_LINES);
  localparam int unsigned CNT_W = $clog2(MAX_LINES + 1);
  localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_LINES);
  localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);
  localparam logic [CMP_W-1:0] TWO_C = CMP_W'(2);

  // controller state
  state_t state_r, state_nxt;

  // registered transaction and result
  logic [CNT_W-1:0]        count_r, count_nxt;
  status_t                 status_r, status_nxt;
  cell_ctl_t               ctl_r, ctl_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [CNT_W-1:0]        ld_r, ld_nxt;
  logic [IDX_W-1:0]        n0_r, n0_nxt;
  logic                    at_ok_r, at_ok_nxt;
  logic [HANDLE_WIDTH-1:0] handle_r;

  logic                    accept;
  logic                    load_regs;
  logic [CMP_W-1:0]        n_c, m_c, cnt_c, n0_c, m0_c, new_cnt_c;
  logic                    n_ok, m_ok, n_ok_ins;
  cmd_t                    cmd;
  cell_ctl_t               ctl_exec;

  logic [HANDLE_WIDTH-1:0] cell_q [MAX_LINES];
  logic [HANDLE_WIDTH-1:0] rd_data;

  assign accept = in_valid && !in_stall;
  assign cmd    = cmd_t'(in_cmd);

  // position checks and per-operation control
  always_comb begin
    n_c      = CMP_W'(in_position);
    m_c      = CMP_W'(in_dest_position);
    cnt_c    = CMP_W'(count_r);
    n0_c     = n_c - ONE_C;
    m0_c     = m_c - ONE_C;
    n_ok     = (n_c >= ONE_C) && (n_c <= cnt_c);
    m_ok     = (m_c >= ONE_C) && (m_c <= cnt_c);
    n_ok_ins = (n_c >= ONE_C) && (n_c <= cnt_c + ONE_C);

    new_cnt_c  = cnt_c;
    status_nxt = ST_DONE;
    ctl_nxt    = '0;
    lo_nxt     = '0;
    hi_nxt     = '0;
    ld_nxt     = CNT_W'(n0_c);

    unique case (cmd)
      CMD_INSERT: begin
        if (!n_ok_ins) begin
          status_nxt = ST_BAD_LINE;
        end else if (cnt_c >= MAX_C) begin
          status_nxt = ST_FULL;
        end else begin
          ctl_nxt.load_en   = 1'b1;
          ctl_nxt.shift_en  = 1'b1;
          ctl_nxt.from_left = 1'b1;
          lo_nxt            = CNT_W'(n0_c + ONE_C);
          hi_nxt            = CNT_W'(cnt_c);
          new_cnt_c         = cnt_c + ONE_C;
        end
      end
      CMD_DELETE: begin
        if (!n_ok) begin
          status_nxt = ST_BAD_LINE;
        end else begin
          ctl_nxt.shift_en = (n_c < cnt_c);
          lo_nxt           = CNT_W'(n0_c);
          hi_nxt           = CNT_W'(cnt_c - TWO_C);
          new_cnt_c        = cnt_c - ONE_C;
        end
      end
      CMD_REPLACE: begin
        if (!n_ok) begin
          status_nxt = ST_BAD_LINE;
        end else begin
          ctl_nxt.load_en = 1'b1;
        end
      end
      CMD_MOVE: begin
        if (!n_ok || !m_ok || (n_c == m_c)) begin
          status_nxt = ST_BAD_LINE;
        end else if (n_c < m_c) begin
          // lines between move down one place, moved line lands at m
          ctl_nxt.load_en   = 1'b1;
          ctl_nxt.src_moved = 1'b1;
          ctl_nxt.shift_en  = 1'b1;
          lo_nxt            = CNT_W'(n0_c);
          hi_nxt            = CNT_W'(m0_c - ONE_C);
          ld_nxt            = CNT_W'(m0_c);
        end else begin
          // lines between move up one place, moved line lands after m
          ctl_nxt.load_en   = 1'b1;
          ctl_nxt.src_moved = 1'b1;
          ctl_nxt.shift_en  = 1'b1;
          ctl_nxt.from_left = 1'b1;
          lo_nxt            = CNT_W'(m0_c + TWO_C);
          hi_nxt            = CNT_W'(n0_c);
          ld_nxt            = CNT_W'(m0_c + ONE_C);
        end
      end
      default: begin
        status_nxt = ST_BAD_LINE;
      end
    endcase

    count_nxt = CNT_W'(new_cnt_c);
    n0_nxt    = IDX_W'(n0_c);
    at_ok_nxt = (n_c >= ONE_C) && (n_c <= new_cnt_c);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_DONE;
      S_DONE:  if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ctl_exec  = ctl_r;
    ctl_exec.en = 1'b0;
    unique case (state_r)
      S_IDLE:  in_stall = 1'b0;
      S_EXEC:  ctl_exec.en = 1'b1;
      S_DONE:  out_valid = 1'b1;
      S_FETCH, S_LOOK: begin
      end
      default: begin
      end
    endcase
  end

  assign load_regs = accept;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_regs) begin
        count_r <= count_nxt;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (load_regs) begin
      status_r <= status_nxt;
      ctl_r    <= ctl_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      ld_r     <= ld_nxt;
      n0_r     <= n0_nxt;
      at_ok_r  <= at_ok_nxt;
      handle_r <= HANDLE_WIDTH'(in_line_handle);
    end
  end

  // chain of cells
  for (genvar i = 0; i < MAX_LINES; i++) begin : g_cell
    logic [HANDLE_WIDTH-1:0] left_q;
    logic [HANDLE_WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end

    if (i == MAX_LINES - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end

    pll_cell #(
      .IDX   (i),
      .HW    (HANDLE_WIDTH),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl_exec),
      .lo      (lo_r),
      .hi      (hi_r),
      .ld_idx  (ld_r),
      .handle  (handle_r),
      .moved   (rd_data),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i])
    );
  end

  // shared read port: moved line before the update, result line after it
  pll_read #(
    .MAX_LINES (MAX_LINES),
    .HW        (HANDLE_WIDTH),
    .IDX_W     (IDX_W)
  ) u_read (
    .clk   (clk),
    .cells (cell_q),
    .idx   (n0_r),
    .data  (rd_data)
  );

  // result outputs, stable while the result waits
  assign out_status           = status_r;
  assign out_line_count       = count_r;
  assign out_line_at_position = at_ok_r ? PORT_H_W'(rd_data) : '0;

endmodule

`default_nettype wire

// ===== src/pll_cell.sv =====
// one storage cell of the line chain
// holds one handle; loads, shifts from a neighbor or holds; uses pll_pkg
`default_nettype none

module pll_cell
  import pll_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned HW    = 32,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic             clk,
  input  wire cell_ctl_t        ctl,
  input  wire logic [CNT_W-1:0] lo,
  input  wire logic [CNT_W-1:0] hi,
  input  wire logic [CNT_W-1:0] ld_idx,
  input  wire logic [HW-1:0]    handle,
  input  wire logic [HW-1:0]    moved,
  input  wire logic [HW-1:0]    left_q,
  input  wire logic [HW-1:0]    right_q,
  output logic      [HW-1:0]    q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [HW-1:0] q_r;
  logic [HW-1:0] q_nxt;
  logic          in_range;

  // decide this cell's next value from its own position
  always_comb begin
    in_range = (MY_IDX >= lo) && (MY_IDX <= hi);
    q_nxt    = q_r;
    priority if (ctl.en && ctl.load_en && (MY_IDX == ld_idx)) begin
      q_nxt = ctl.src_moved ? moved : handle;
    end else if (ctl.en && ctl.shift_en && in_range) begin
      q_nxt = ctl.from_left ? left_q : right_q;
    end else begin
      q_nxt = q_r;
    end
  end

  // handle storage, no reset
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== src/pll_read.sv =====
// registered read port over the cell chain
// selects the cell at one index and registers it; no package use
`default_nettype none

module pll_read #(
  parameter int unsigned MAX_LINES = 64,
  parameter int unsigned HW        = 32,
  parameter int unsigned IDX_W     = 6
) (
  input  wire logic             clk,
  input  wire logic [HW-1:0]    cells [MAX_LINES],
  input  wire logic [IDX_W-1:0] idx,
  output logic      [HW-1:0]    data
);

  logic [HW-1:0] sel;
  logic [HW-1:0] data_r;

  // and-or select across all cells
  always_comb begin
    sel = '0;
    for (int i = 0; i < MAX_LINES; i++) begin
      if (idx == IDX_W'(i)) begin
        sel = sel | cells[i];
      end
    end
  end

  // registered read data
  always_ff @(posedge clk) begin
    data_r <= sel;
  end

  assign data = data_r;

endmodule

`default_nettype wire
